[hw/rtl/ptmw_pkg.sv]
// shared types, command codes and mask helper for the palette table
`timescale 1ns / 1ps

package ptmw_pkg;

	typedef enum logic [1:0] {
		CMD_READ  = 2'd0,
		CMD_WRITE = 2'd1,
		CMD_MASK  = 2'd2,
		CMD_FILL  = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_READ,
		S_MASK,
		S_FILL
	} state_t;

	function automatic logic [7:0] layer_mask(input logic [7:0] pattern, input logic [7:0] ob);
		logic [8:0] below_inc;
		logic [7:0] mask;
		below_inc = {ob, 1'b0} - 9'd1;
		mask = pattern;
		if (({1'b0, pattern} & below_inc) != 9'd0) begin
			mask = mask | ob;
		end
		if ((pattern & ob) != 8'd0) begin
			mask = mask | (ob - 8'd1);
		end
		return mask;
	endfunction

endpackage

[hw/rtl/palette_table_masked_write.sv]
// palette table top level: command sequencer, entry store and result registers
`timescale 1ns / 1ps

// Palette store of ENTRIES 24-bit RGB entries held in one synchronous RAM with
// a single write port and a registered read port. After reset the block clears
// the RAM one entry per cycle; busy stays high until the last is cleared; the
// opaque bit register may be written during that time. A command is taken when
// start is high and busy is low. A write, or a run fill with a rejected end,
// finishes from the idle state; a read uses the registered read port; a masked
// write visits every entry one per cycle; a run fill writes one entry per cycle
// from the fill pointer to the end index. Each result appears for exactly one
// cycle with done high; the receiver cannot hold it off, so it must take every
// result as it comes. A new command may be started in the cycle done is high.
module palette_table_masked_write
	import ptmw_pkg::*;
#(
	parameter int ENTRIES = 256
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic [7:0] cfg_wr_data,
	input  logic       start,
	output logic       busy,
	input  logic [1:0] cmd,
	input  logic [7:0] index,
	input  logic [7:0] red_in,
	input  logic [7:0] green_in,
	input  logic [7:0] blue_in,
	output logic       done,
	output logic [7:0] red_out,
	output logic [7:0] green_out,
	output logic [7:0] blue_out,
	output logic       status,
	output logic       map_updated,
	output logic [8:0] fill_next
);

	localparam int AW = $clog2(ENTRIES);
	localparam logic [AW-1:0] LAST = AW'(ENTRIES - 1);

	logic [23:0] mem [ENTRIES];

	state_t      state_q, state_d;
	logic [AW-1:0] ptr_q, ptr_d;
	logic [8:0]  fill_q, fill_d;
	logic [7:0]  opaque_q;
	logic [7:0]  mask_q, pat_q, end_q;
	logic [23:0] rgb_q;
	logic        rd_ok_q;
	logic [23:0] rd_data_q;

	logic        done_q, done_d;
	logic [7:0]  red_q, red_d, green_q, green_d, blue_q, blue_d;
	logic        status_q, status_d, upd_q, upd_d;
	logic [8:0]  next_q;

	logic          accept;
	logic          in_range;
	logic [8:0]    fill_start;
	logic          fill_err;
	logic          mem_we, mem_re;
	logic [AW-1:0] mem_waddr, mem_raddr;
	logic [23:0]   mem_wdata;

	assign accept     = start && (state_q == S_IDLE);
	assign in_range   = 32'(index) < ENTRIES;
	assign fill_start = (32'(fill_q) >= ENTRIES) ? 9'd0 : fill_q;
	assign fill_err   = ({1'b0, index} < fill_start) || (32'(index) > ENTRIES - 1);
	assign mem_raddr  = AW'(index);

	always_comb begin
		state_d   = state_q;
		ptr_d     = ptr_q;
		fill_d    = fill_q;
		done_d    = 1'b0;
		red_d     = 8'd0;
		green_d   = 8'd0;
		blue_d    = 8'd0;
		status_d  = 1'b0;
		upd_d     = 1'b0;
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		mem_waddr = ptr_q;
		mem_wdata = rgb_q;
		case (state_q)
			S_CLEAR: begin
				mem_we    = 1'b1;
				mem_wdata = 24'd0;
				if (ptr_q == LAST) begin
					ptr_d   = '0;
					state_d = S_IDLE;
				end else begin
					ptr_d = ptr_q + 1'b1;
				end
			end
			S_IDLE: begin
				if (start) begin
					case (cmd_t'(cmd))
						CMD_READ: begin
							mem_re  = 1'b1;
							state_d = S_READ;
						end
						CMD_WRITE: begin
							mem_we    = in_range;
							mem_waddr = AW'(index);
							mem_wdata = {red_in, green_in, blue_in};
							done_d    = 1'b1;
							upd_d     = 1'b1;
						end
						CMD_MASK: begin
							ptr_d   = '0;
							state_d = S_MASK;
						end
						CMD_FILL: begin
							if (fill_err) begin
								fill_d   = 9'd0;
								status_d = 1'b1;
								done_d   = 1'b1;
							end else begin
								ptr_d   = AW'(fill_start);
								state_d = S_FILL;
							end
						end
						default: begin
							state_d = S_IDLE;
						end
					endcase
				end
			end
			S_READ: begin
				done_d  = 1'b1;
				state_d = S_IDLE;
				if (rd_ok_q) begin
					red_d   = rd_data_q[23:16];
					green_d = rd_data_q[15:8];
					blue_d  = rd_data_q[7:0];
				end
			end
			S_MASK: begin
				mem_we = ((8'(ptr_q) & mask_q) == pat_q);
				if (ptr_q == LAST) begin
					ptr_d   = '0;
					done_d  = 1'b1;
					upd_d   = 1'b1;
					state_d = S_IDLE;
				end else begin
					ptr_d = ptr_q + 1'b1;
				end
			end
			S_FILL: begin
				mem_we = 1'b1;
				if (ptr_q == AW'(end_q)) begin
					fill_d  = {1'b0, end_q} + 9'd1;
					upd_d   = (32'(end_q) + 1 >= ENTRIES);
					done_d  = 1'b1;
					state_d = S_IDLE;
				end else begin
					ptr_d = ptr_q + 1'b1;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_CLEAR;
			ptr_q    <= '0;
			fill_q   <= 9'd0;
			opaque_q <= 8'd64;
			done_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			ptr_q   <= ptr_d;
			fill_q  <= fill_d;
			done_q  <= done_d;
			if (cfg_wr_en) begin
				opaque_q <= cfg_wr_data;
			end
		end
	end

	// command operands and result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			mask_q  <= layer_mask(index, opaque_q);
			pat_q   <= index;
			end_q   <= index;
			rgb_q   <= {red_in, green_in, blue_in};
			rd_ok_q <= in_range;
		end
		if (done_d) begin
			red_q    <= red_d;
			green_q  <= green_d;
			blue_q   <= blue_d;
			status_q <= status_d;
			upd_q    <= upd_d;
			next_q   <= fill_d;
		end
	end

	// entry store
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rd_data_q <= mem[mem_raddr];
		end
	end

	assign busy        = (state_q != S_IDLE);
	assign done        = done_q;
	assign red_out     = red_q;
	assign green_out   = green_q;
	assign blue_out    = blue_q;
	assign status      = status_q;
	assign map_updated = upd_q;
	assign fill_next   = next_q;

`ifndef SYNTHESIS
	a_done_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy || start))
		else $error("result transfer without a command in flight");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result transfer while still busy");

	a_error_resets_pointer: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status) |-> (fill_next == 9'd0) && !map_updated)
		else $error("rejected run fill left the pointer set");

	a_pointer_bound: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (32'(fill_next) <= ENTRIES))
		else $error("fill pointer beyond the store");
`endif

endmodule

[sim/palette_table_masked_write_test.sv]
// self-checking testbench for the palette table: directed corners, opaque bit sweep, run fills, random mix
`timescale 1ns / 1ps

module palette_table_masked_write_test;
	import ptmw_pkg::*;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       status;
		logic       map_updated;
		logic [8:0] fill_next;
	} palette_result_t;

	localparam int PALETTE_SIZE = 256;
	localparam logic [7:0] LAST_INDEX = 8'd255;

	logic       clk;
	logic       arst_n;
	logic       cfg_wr_en;
	logic [7:0] cfg_wr_data;
	logic       start;
	logic       busy;
	cmd_t       cmd;
	logic [7:0] index;
	logic [7:0] red_in;
	logic [7:0] green_in;
	logic [7:0] blue_in;
	logic       done;
	logic [7:0] red_out;
	logic [7:0] green_out;
	logic [7:0] blue_out;
	logic       status;
	logic       map_updated;
	logic [8:0] fill_next;

	// shadow copy of the palette, fill pointer and opaque bit
	logic [23:0]     palette_shadow [PALETTE_SIZE];
	logic [8:0]      fill_shadow;
	logic [7:0]      opaque_shadow;
	palette_result_t pending_results [$];
	palette_result_t oldest_result;
	int              error_count;
	bit              gaps_on;

	palette_table_masked_write dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.start      (start),
		.busy       (busy),
		.cmd        (cmd),
		.index      (index),
		.red_in     (red_in),
		.green_in   (green_in),
		.blue_in    (blue_in),
		.done       (done),
		.red_out    (red_out),
		.green_out  (green_out),
		.blue_out   (blue_out),
		.status     (status),
		.map_updated(map_updated),
		.fill_next  (fill_next)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	task automatic predict_command(input cmd_t op, input logic [7:0] idx,
		input logic [23:0] rgb, output palette_result_t res);
		logic [8:0] opaque_and_below;
		logic [7:0] mask;
		logic [8:0] first;
		res = '0;
		case (op)
			CMD_READ: begin
				{res.red, res.green, res.blue} = palette_shadow[idx];
			end
			CMD_WRITE: begin
				palette_shadow[idx] = rgb;
				res.map_updated = 1'b1;
			end
			CMD_MASK: begin
				opaque_and_below = {1'b0, opaque_shadow} + {1'b0, opaque_shadow} - 9'd1;
				mask = idx;
				if (({1'b0, idx} & opaque_and_below) != 9'd0)
					mask = mask | opaque_shadow;
				if ((idx & opaque_shadow) != 8'd0)
					mask = mask | (opaque_shadow - 8'd1);
				for (int i = 0; i < PALETTE_SIZE; i++)
					if ((8'(i) & mask) == idx)
						palette_shadow[i] = rgb;
				res.map_updated = 1'b1;
			end
			default: begin
				first = (fill_shadow >= PALETTE_SIZE) ? 9'd0 : fill_shadow;
				if ({1'b0, idx} < first) begin
					res.status = 1'b1;
					fill_shadow = 9'd0;
				end else begin
					for (int i = int'(first); i <= int'(idx); i++)
						palette_shadow[i] = rgb;
					fill_shadow = {1'b0, idx} + 9'd1;
					if (fill_shadow == PALETTE_SIZE)
						res.map_updated = 1'b1;
				end
			end
		endcase
		res.fill_next = fill_shadow;
	endtask

	task automatic send_command(input cmd_t op, input logic [7:0] idx,
		input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
		int gap;
		palette_result_t res;
		gap = gaps_on ? $urandom_range(0, 11) : 0;
		if (gap > 0) begin
			// junk on the fields while start is low must be ignored
			start <= 1'b0;
			cmd <= cmd_t'(2'($urandom_range(0, 3)));
			index <= 8'($urandom_range(0, 255));
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		cmd <= op;
		index <= idx;
		red_in <= r;
		green_in <= g;
		blue_in <= b;
		@(posedge clk);
		while (busy) @(posedge clk);
		predict_command(op, idx, {r, g, b}, res);
		pending_results.push_back(res);
	endtask

	function automatic logic [7:0] pick_fill_end(input bit well_formed);
		int first;
		int stop;
		first = (fill_shadow >= PALETTE_SIZE) ? 0 : int'(fill_shadow);
		if (!well_formed && first > 0)
			return 8'($urandom_range(0, first - 1));
		if ($urandom_range(0, 9) == 0)
			return LAST_INDEX;
		stop = first + $urandom_range(0, 15);
		return (stop > 255) ? LAST_INDEX : 8'(stop);
	endfunction

	task automatic send_random(input cmd_t op, input bit well_formed);
		logic [7:0] idx;
		if ($urandom_range(0, 49) == 0)
			gaps_on = !gaps_on;
		idx = (op == CMD_FILL) ? pick_fill_end(well_formed) : 8'($urandom_range(0, 255));
		send_command(op, idx, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
			8'($urandom_range(0, 255)));
	endtask

	task automatic drain_results();
		start <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	task automatic set_opaque_bit(input logic [7:0] value);
		drain_results();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		opaque_shadow = value;
	endtask

	task automatic compare_field(input string name, input logic [8:0] want, input logic [8:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, actual %0h", name, want, got);
			error_count++;
		end
	endtask

	task automatic test_directed();
		set_opaque_bit(8'd64);
		send_command(CMD_WRITE, 8'd0, 8'h00, 8'h00, 8'h00);
		send_command(CMD_WRITE, LAST_INDEX, 8'hFF, 8'hFF, 8'hFF);
		send_command(CMD_READ, 8'd0, 8'h00, 8'h00, 8'h00);
		send_command(CMD_READ, LAST_INDEX, 8'h00, 8'h00, 8'h00);
		// empty pattern gives an empty mask, so every entry is written
		send_command(CMD_MASK, 8'h00, 8'h11, 8'h22, 8'h33);
		send_command(CMD_READ, 8'd200, 8'h00, 8'h00, 8'h00);
		// opaque pattern pulls in all colour bits
		send_command(CMD_MASK, 8'h40, 8'hA5, 8'h5A, 8'hC3);
		send_command(CMD_READ, 8'hC0, 8'h00, 8'h00, 8'h00);
		send_command(CMD_READ, 8'h40, 8'h00, 8'h00, 8'h00);
		send_command(CMD_READ, 8'h41, 8'h00, 8'h00, 8'h00);
		// bits above the opaque bit only
		send_command(CMD_MASK, 8'h80, 8'h01, 8'h02, 8'h03);
		// colour bits pull in the opaque bit
		send_command(CMD_MASK, 8'h05, 8'hFE, 8'hDC, 8'hBA);
		send_command(CMD_READ, 8'h45, 8'h00, 8'h00, 8'h00);
		send_command(CMD_READ, 8'h05, 8'h00, 8'h00, 8'h00);
		send_command(CMD_FILL, 8'd9, 8'h10, 8'h20, 8'h30);
		// end below the pointer is rejected
		send_command(CMD_FILL, 8'd5, 8'hEE, 8'hEE, 8'hEE);
		send_command(CMD_FILL, 8'd0, 8'h40, 8'h50, 8'h60);
		// fill to the last entry completes the map
		send_command(CMD_FILL, LAST_INDEX, 8'h70, 8'h80, 8'h90);
		// a fill after completion restarts from zero
		send_command(CMD_FILL, 8'd3, 8'hAB, 8'hCD, 8'hEF);
		send_command(CMD_READ, 8'd2, 8'h00, 8'h00, 8'h00);
	endtask

	task automatic test_opaque_settings();
		logic [7:0] settings [8];
		int pick;
		settings = '{8'd1, 8'd128, 8'd0, 8'hFF, 8'h24, 8'd2, 8'd16, 8'd32};
		foreach (settings[s]) begin
			set_opaque_bit(settings[s]);
			repeat (30) begin
				pick = $urandom_range(0, 19);
				if (pick < 10)
					send_random(CMD_MASK, 1'b1);
				else if (pick < 17)
					send_random(CMD_READ, 1'b1);
				else
					send_random(CMD_WRITE, 1'b1);
			end
		end
	endtask

	task automatic test_fill_runs();
		int pick;
		set_opaque_bit(8'(1 << $urandom_range(0, 7)));
		repeat (400) begin
			pick = $urandom_range(0, 99);
			if (pick < 60)
				send_random(CMD_FILL, 1'b1);
			else if (pick < 70)
				send_random(CMD_FILL, 1'b0);
			else if (pick < 85)
				send_random(CMD_READ, 1'b1);
			else
				send_random(CMD_WRITE, 1'b1);
		end
	endtask

	task automatic test_random_mix();
		int pick;
		repeat (6) begin
			if ($urandom_range(0, 3) == 0)
				set_opaque_bit(8'($urandom_range(0, 255)));
			else
				set_opaque_bit(8'(1 << $urandom_range(0, 7)));
			repeat (190) begin
				pick = $urandom_range(0, 99);
				if (pick < 30)
					send_random(CMD_READ, 1'b1);
				else if (pick < 55)
					send_random(CMD_WRITE, 1'b1);
				else if (pick < 70)
					send_random(CMD_MASK, 1'b1);
				else
					send_random(CMD_FILL, $urandom_range(0, 5) != 0);
			end
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				$error("result transfer with no command pending");
				error_count++;
			end else begin
				oldest_result = pending_results.pop_front();
				compare_field("red_out", {1'b0, oldest_result.red}, {1'b0, red_out});
				compare_field("green_out", {1'b0, oldest_result.green}, {1'b0, green_out});
				compare_field("blue_out", {1'b0, oldest_result.blue}, {1'b0, blue_out});
				compare_field("status", {8'd0, oldest_result.status}, {8'd0, status});
				compare_field("map_updated", {8'd0, oldest_result.map_updated},
					{8'd0, map_updated});
				compare_field("fill_next", oldest_result.fill_next, fill_next);
			end
		end
	end

	initial begin
		#20_000_000;
		$display("Mismatches found");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = 8'd0;
		start = 1'b0;
		cmd = CMD_READ;
		index = 8'd0;
		red_in = 8'd0;
		green_in = 8'd0;
		blue_in = 8'd0;
		error_count = 0;
		gaps_on = 1'b1;
		fill_shadow = 9'd0;
		opaque_shadow = 8'd64;
		foreach (palette_shadow[i])
			palette_shadow[i] = 24'd0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_opaque_settings();
		test_fill_runs();
		test_random_mix();
		drain_results();
		repeat (8) @(posedge clk);
		if (error_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

[files.f]
hw/rtl/ptmw_pkg.sv
hw/rtl/palette_table_masked_write.sv
sim/palette_table_masked_write_test.sv
